### hw/rtl/sct_pkg.sv
// shared types, codes and the scancode to ascii table for the scancode fifo
package sct_pkg;

  localparam logic [7:0] SC_CTRL     = 8'h1D;
  localparam logic [7:0] SC_KEY_C    = 8'h2E;
  localparam logic [7:0] SC_KEY_D    = 8'h20;
  localparam logic [7:0] SC_KEY_AMP  = 8'h07;
  localparam logic [7:0] SC_KEY_PIPE = 8'h02;
  localparam logic [7:0] SC_ROM_END  = 8'h53;
  localparam logic [7:0] CH_NONE     = 8'hFF;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_PIPE     = 8'h7C;

  localparam logic       ACT_SCAN = 1'b0;
  localparam logic       ACT_POP  = 1'b1;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_CTRL_C = 2'd1;
  localparam logic [1:0] EV_CTRL_D = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] scancode;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       queue_empty;
    logic [1:0] ctrl_event;
    logic       dropped;
  } out_item_t;

  // what one scancode asks of the queue and the ctrl flag
  typedef struct packed {
    logic       push;
    logic [7:0] byte_val;
    logic [1:0] ev;
    logic       ctrl_nxt;
  } xlate_t;

  function automatic logic [7:0] key_rom(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'd2:  ch = 8'h31;
      7'd3:  ch = 8'h32;
      7'd4:  ch = 8'h33;
      7'd5:  ch = 8'h34;
      7'd6:  ch = 8'h35;
      7'd7:  ch = 8'h36;
      7'd8:  ch = 8'h37;
      7'd9:  ch = 8'h38;
      7'd10: ch = 8'h39;
      7'd11: ch = 8'h30;
      7'd12: ch = 8'h2D;
      7'd13: ch = 8'h3D;
      7'd14: ch = 8'h7F;
      7'd15: ch = 8'h09;
      7'd16: ch = 8'h71;
      7'd17: ch = 8'h77;
      7'd18: ch = 8'h65;
      7'd19: ch = 8'h72;
      7'd20: ch = 8'h74;
      7'd21: ch = 8'h79;
      7'd22: ch = 8'h75;
      7'd23: ch = 8'h69;
      7'd24: ch = 8'h6F;
      7'd25: ch = 8'h70;
      7'd26: ch = 8'h5B;
      7'd27: ch = 8'h5D;
      7'd28: ch = 8'h0A;
      7'd29: ch = 8'h7C;
      7'd30: ch = 8'h61;
      7'd31: ch = 8'h73;
      7'd32: ch = 8'h64;
      7'd33: ch = 8'h66;
      7'd34: ch = 8'h67;
      7'd35: ch = 8'h68;
      7'd36: ch = 8'h6A;
      7'd37: ch = 8'h6B;
      7'd38: ch = 8'h6C;
      7'd39: ch = 8'h3B;
      7'd40: ch = 8'h22;
      7'd43: ch = 8'h5C;
      7'd44: ch = 8'h7A;
      7'd45: ch = 8'h78;
      7'd46: ch = 8'h63;
      7'd47: ch = 8'h76;
      7'd48: ch = 8'h62;
      7'd49: ch = 8'h6E;
      7'd50: ch = 8'h6D;
      7'd51: ch = 8'h2C;
      7'd52: ch = 8'h2E;
      7'd53: ch = 8'h2F;
      7'd55: ch = 8'h2A;
      7'd57: ch = 8'h20;
      7'd72: ch = 8'h55;
      7'd75: ch = 8'h4C;
      7'd77: ch = 8'h52;
      7'd80: ch = 8'h44;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### hw/rtl/sct_char_ram.sv
// character store: one write port, one registered read port
module sct_char_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  // read returns the old word when the same address is written this cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### hw/rtl/sct_xlate.sv
// scancode decode: ctrl combinations and the ascii table
module sct_xlate import sct_pkg::*; (
  input  logic [7:0] scancode,
  input  logic       ctrl_held,
  output xlate_t     xl
);

  always_comb begin
    xl.push     = 1'b0;
    xl.byte_val = 8'h00;
    xl.ev       = EV_NONE;
    xl.ctrl_nxt = 1'b0;
    if (scancode == SC_CTRL) begin
      xl.ctrl_nxt = 1'b1;
    end else if (ctrl_held && scancode == SC_KEY_C) begin
      xl.ev = EV_CTRL_C;
    end else if (ctrl_held && scancode == SC_KEY_D) begin
      xl.ev = EV_CTRL_D;
    end else if (ctrl_held && scancode == SC_KEY_AMP) begin
      xl.push     = 1'b1;
      xl.byte_val = CH_AMP;
    end else if (ctrl_held && scancode == SC_KEY_PIPE) begin
      xl.push     = 1'b1;
      xl.byte_val = CH_PIPE;
    end else if (scancode < SC_ROM_END) begin
      xl.push     = 1'b1;
      xl.byte_val = key_rom(scancode[6:0]);
    end
  end

endmodule

### hw/rtl/scancode_translate_fifo.sv
// top level: scancode translation into a ring fifo with pop requests
// Every request, scancode or pop, gives one result in the output register on
// the next cycle; a new request is taken each cycle unless a waiting result is
// stalled. The oldest character is prefetched from the character RAM (a
// single registered read port) at the head pointer of the coming cycle, with
// a bypass for a push into the slot being fetched, so back-to-back pops and
// push/pop mixes need no wait cycles. A push into a full queue is dropped and
// flagged; ctrl+C and ctrl+D only raise ctrl_event.
module scancode_translate_fifo import sct_pkg::*; #(
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             ctrl_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             byp_r;
  logic [7:0]       byp_data_r;
  logic [7:0]       ram_rdata;
  logic [7:0]       head_char;
  xlate_t           xl;
  logic             in_fire, is_pop, is_scan, full, empty, push_ok, pop_ok, drop;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign is_pop   = in_fire & (in_data.action == ACT_POP);
  assign is_scan  = in_fire & (in_data.action == ACT_SCAN);
  assign full     = (fill_r == CNT_FULL);
  assign empty    = (fill_r == '0);
  assign push_ok  = is_scan & xl.push & ~full;
  assign drop     = is_scan & xl.push & full;
  assign pop_ok   = is_pop & ~empty;

  sct_xlate u_xlate (
    .scancode  (in_data.scancode),
    .ctrl_held (ctrl_r),
    .xl        (xl)
  );

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (pop_ok) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
      fill_nxt = fill_r - CNT_W'(1);
    end
    if (push_ok) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  sct_char_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_ram (
    .clk     (clk),
    .we      (push_ok),
    .waddr   (tail_r),
    .wdata   (xl.byte_val),
    .raddr   (head_nxt),
    .rdata_r (ram_rdata)
  );

  // the ram reads before write, so a push into the slot being fetched is forwarded
  always_ff @(posedge clk) begin
    byp_data_r <= xl.byte_val;
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= push_ok && (tail_r == head_nxt);
    end
  end

  assign head_char = byp_r ? byp_data_r : ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      ctrl_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      if (is_scan) begin
        ctrl_r <= xl.ctrl_nxt;
      end
      out_valid_r <= in_fire | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.read_char   <= pop_ok ? head_char : CH_NONE;
      out_data_r.queue_empty <= is_pop & empty;
      out_data_r.ctrl_event  <= is_scan ? xl.ev : EV_NONE;
      out_data_r.dropped     <= drop;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/sct_checker.sv
// port-level checker for the scancode fifo, bound to the top level
module sct_checker import sct_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request gave no result");

  a_empty_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.queue_empty |->
      out_data.read_char == CH_NONE && out_data.ctrl_event == EV_NONE && !out_data.dropped)
    else $error("empty pop carries data");

  a_event_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ctrl_event != EV_NONE |->
      (out_data.ctrl_event == EV_CTRL_C || out_data.ctrl_event == EV_CTRL_D) &&
      out_data.read_char == CH_NONE && !out_data.dropped)
    else $error("bad ctrl event result");

  a_drop_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |-> out_data.read_char == CH_NONE)
    else $error("dropped push returned a character");

endmodule

bind scancode_translate_fifo sct_checker u_sct_checker (.*);
